@@ rtl/core/baro_temp_pressure_compensation_core_defines.svh @@
// Assertion macros shared by the compensation core RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/btpc_pkg.sv @@
// Shared types and constants of the barometric compensation core.
// Depends on nothing; used by the divider, the top level and the testbench.
package btpc_pkg;

  typedef enum logic [1:0] {
    CFG_TEMP_COEFFS   = 2'd0,
    CFG_PRESS_A       = 2'd1,
    CFG_PRESS_B       = 2'd2,
    CFG_PRESS_NINE    = 2'd3
  } cfg_idx_t;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic        vld;
    logic        pvalid;
    logic [15:0] temp;
  } div_tag_t;

endpackage

@@ rtl/core/btpc_in_if.sv @@
// Input channel of the compensation core: one raw temperature and pressure pair.
// Depends on nothing.
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source(output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

@@ rtl/core/btpc_out_if.sv @@
// Result channel of the compensation core: temperature, pressure and its valid flag.
// Depends on nothing.
interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centideg;
  logic [31:0]        pressure_q24_8;
  logic               pressure_valid;

  modport source(output valid, output temperature_centideg, output pressure_q24_8,
                 output pressure_valid, input ready);
  modport sink(input valid, input temperature_centideg, input pressure_q24_8,
               input pressure_valid, output ready);
endinterface

@@ rtl/core/btpc_mul64.sv @@
// Two-stage 64 by 64 multiplier that keeps the low 64 bits of the product.
// Depends on nothing; instanced by the top level.
module btpc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;
  logic [63:0] lh_full;
  logic [63:0] hl_full;

  // Only the low half of each cross product reaches the low 64 bits.
  assign lh_full = a[31:0] * b[63:32];
  assign hl_full = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      lh_r <= lh_full[31:0];
      hl_r <= hl_full[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

@@ rtl/core/btpc_div.sv @@
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage, truncating.
// Depends on btpc_pkg for the step count and the side tag type.
module btpc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [63:0]         in_num,
  input  logic [30:0]         in_den,
  input  btpc_pkg::div_tag_t  in_tag,
  output logic [63:0]         out_quo,
  output btpc_pkg::div_tag_t  out_tag
);

  localparam int N = btpc_pkg::DIV_STEPS;

  logic [30:0]        rem_r [0:N];
  logic [63:0]        quo_r [0:N];
  logic [30:0]        dvs_r [0:N];
  logic               neg_r [0:N];
  btpc_pkg::div_tag_t tag_r [0:N];
  logic [63:0]        quo_out_r;
  btpc_pkg::div_tag_t tag_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= in_num[63] ? (64'd0 - in_num) : in_num;
      dvs_r[0] <= in_den[30] ? (31'd0 - in_den) : in_den;
      neg_r[0] <= in_num[63] ^ in_den[30];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[k], quo_r[k][63]};
      diff  = trial - {1'b0, dvs_r[k]};
      ge    = trial >= {1'b0, dvs_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else if (en) begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[30:0] : trial[30:0];
        quo_r[k+1] <= {quo_r[k][62:0], ge};
        dvs_r[k+1] <= dvs_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_out_r <= '0;
    end else if (en) begin
      tag_out_r <= tag_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_out_r <= neg_r[N] ? (64'd0 - quo_r[N]) : quo_r[N];
    end
  end

  assign out_quo = quo_out_r;
  assign out_tag = tag_out_r;

endmodule

@@ rtl/core/baro_temp_pressure_compensation_core.sv @@
// Barometric temperature and pressure compensation core. Each item carries one raw
// 20-bit temperature and one raw 20-bit pressure reading; the core returns the
// temperature in 0.01 degrees C (saturated to 16 bits signed) and the pressure in
// pascals as unsigned Q24.8, using the 64-bit integer form of the compensation with
// wrapping arithmetic. One item can be accepted in every clock cycle while the result
// channel keeps up; the whole pipeline halts only while a finished result waits. Each
// item passes 86 register stages before its result is presented; 66 of those are the
// bit-per-stage divider, the rest are the stages before and after it. A zero pressure
// divisor gives pressure 0 with pressure_valid low. The user must write calibration
// words on the cfg port only while no item is in flight; the core does not enforce it.
// Depends on btpc_pkg, btpc_in_if, btpc_out_if, btpc_mul64, btpc_div and the defines.
`include "baro_temp_pressure_compensation_core_defines.svh"

module baro_temp_pressure_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  btpc_in_if.sink     in_ch,
  btpc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Calibration registers.
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_nine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_nine_r  <= '0;
    end else if (cfg_we) begin
      unique case (btpc_pkg::cfg_idx_t'(cfg_index))
        btpc_pkg::CFG_TEMP_COEFFS: temp_coeffs_r <= cfg_wdata[47:0];
        btpc_pkg::CFG_PRESS_A:     press_a_r     <= cfg_wdata;
        btpc_pkg::CFG_PRESS_B:     press_b_r     <= cfg_wdata;
        btpc_pkg::CFG_PRESS_NINE:  press_nine_r  <= cfg_wdata[15:0];
        default:                   ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs_r[15:0];
  assign t2 = temp_coeffs_r[31:16];
  assign t3 = temp_coeffs_r[47:32];
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_a_r[63:48];
  assign p5 = press_b_r[15:0];
  assign p6 = press_b_r[31:16];
  assign p7 = press_b_r[47:32];
  assign p8 = press_b_r[63:48];
  assign p9 = press_nine_r;

  // The whole pipeline moves as one; it halts only while a finished result waits.
  logic pipe_en;
  logic out_vld_r;

  assign pipe_en     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  // Valid bits and carried payload of the stages before the divider.
  logic        vld_r  [1:14];
  logic [19:0] adcp_r [1:11];
  logic [15:0] temp_r [5:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 14; k++) vld_r[k] <= 1'b0;
    end else if (pipe_en) begin
      vld_r[1] <= in_ch.valid;
      for (int k = 2; k <= 14; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Stage 1: the two temperature differences.
  logic signed [17:0] s1_a_r;
  logic signed [16:0] s1_dd_r;
  // Stage 2: products of the temperature terms.
  logic signed [33:0] s2_m1_r;
  logic signed [33:0] s2_sq_r;
  // Stage 3: first term shifted, quadratic term weighted by T3.
  logic signed [22:0] s3_v1t_r;
  logic signed [37:0] s3_m3_r;
  // Stage 4: fine temperature.
  logic signed [24:0] s4_fine_r;
  // Stage 5: offset fine temperature for the pressure path.
  logic signed [25:0] s5_pv1_r;
  // Stage 6: products of the offset fine temperature.
  logic signed [51:0] s6_sq1_r;
  logic signed [41:0] m5_r [6:8];
  logic signed [41:0] m2_r [6:8];
  // Stage 9 to 11: offset sum and the second pressure variable.
  logic [63:0]        s9_s_r;
  logic [63:0]        v2_r [9:11];
  // Stage 12 to 14: divisor and raw numerator.
  logic [30:0]        den_r [12:14];
  logic [63:0]        s12_num_r;

  logic signed [33:0] m1_c, sq_c;
  logic signed [21:0] sqs_c;
  logic signed [37:0] m3_c;
  logic signed [24:0] fine_c;
  logic signed [27:0] tm_c;
  logic signed [19:0] ts_c;
  logic [15:0]        tsat_c;
  logic [63:0]        prod_a, prod_b, prod_c, prod_d;
  logic [63:0]        v2_c, v1_c;
  logic [20:0]        pa_c;

  assign m1_c   = s1_a_r * t2;
  assign sq_c   = s1_dd_r * s1_dd_r;
  assign sqs_c  = {1'b0, s2_sq_r[32:12]};
  assign m3_c   = sqs_c * t3;
  assign fine_c = {{2{s3_v1t_r[22]}}, s3_v1t_r} + {s3_m3_r[37], s3_m3_r[37:14]};

  // Temperature: (5 * fine + 128) >> 8, then saturation to 16 bits.
  assign tm_c = {{3{s4_fine_r[24]}}, s4_fine_r} + {s4_fine_r[24], s4_fine_r, 2'b00}
                + 28'sd128;
  assign ts_c = tm_c[27:8];

  always_comb begin
    if (ts_c > 20'sd32767) begin
      tsat_c = 16'h7fff;
    end else if (ts_c < -20'sd32768) begin
      tsat_c = 16'h8000;
    end else begin
      tsat_c = ts_c[15:0];
    end
  end

  assign v2_c = prod_a + ({{22{m5_r[8][41]}}, m5_r[8]} << 17)
                + ({{48{p4[15]}}, p4} << 35);
  assign v1_c = {{8{prod_b[63]}}, prod_b[63:8]} + ({{22{m2_r[8][41]}}, m2_r[8]} << 12);
  assign pa_c = 21'd1048576 - {1'b0, adcp_r[11]};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_a_r  <= $signed({1'b0, in_ch.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_dd_r <= $signed({1'b0, in_ch.raw_temperature[19:4]}) - $signed({1'b0, t1});
      adcp_r[1] <= in_ch.raw_pressure;
      for (int k = 2; k <= 11; k++) adcp_r[k] <= adcp_r[k-1];

      s2_m1_r   <= m1_c;
      s2_sq_r   <= sq_c;
      s3_v1t_r  <= s2_m1_r[33:11];
      s3_m3_r   <= m3_c;
      s4_fine_r <= fine_c;

      temp_r[5] <= tsat_c;
      for (int k = 6; k <= 14; k++) temp_r[k] <= temp_r[k-1];
      s5_pv1_r  <= {s4_fine_r[24], s4_fine_r} - 26'sd128000;

      s6_sq1_r <= s5_pv1_r * s5_pv1_r;
      m5_r[6]  <= s5_pv1_r * p5;
      m2_r[6]  <= s5_pv1_r * p2;
      for (int k = 7; k <= 8; k++) begin
        m5_r[k] <= m5_r[k-1];
        m2_r[k] <= m2_r[k-1];
      end

      s9_s_r  <= v1_c + 64'h0000_8000_0000_0000;
      v2_r[9] <= v2_c;
      for (int k = 10; k <= 11; k++) v2_r[k] <= v2_r[k-1];

      den_r[12] <= prod_c[63:33];
      for (int k = 13; k <= 14; k++) den_r[k] <= den_r[k-1];
      s12_num_r <= {12'd0, pa_c, 31'd0} - v2_r[11];
    end
  end

  btpc_mul64 u_mul_p6 (
    .clk(clk), .en(pipe_en),
    .a({{12{s6_sq1_r[51]}}, s6_sq1_r}), .b({{48{p6[15]}}, p6}), .p(prod_a)
  );

  btpc_mul64 u_mul_p3 (
    .clk(clk), .en(pipe_en),
    .a({{12{s6_sq1_r[51]}}, s6_sq1_r}), .b({{48{p3[15]}}, p3}), .p(prod_b)
  );

  btpc_mul64 u_mul_p1 (
    .clk(clk), .en(pipe_en),
    .a(s9_s_r), .b({48'd0, p1}), .p(prod_c)
  );

  btpc_mul64 u_mul_scale (
    .clk(clk), .en(pipe_en),
    .a(s12_num_r), .b(64'd3125), .p(prod_d)
  );

  // Division; the tag carries the temperature and whether the divisor was nonzero.
  btpc_pkg::div_tag_t div_tag_in, div_tag_out;
  logic [63:0]        div_quo;

  assign div_tag_in.vld    = vld_r[14];
  assign div_tag_in.pvalid = den_r[14] != '0;
  assign div_tag_in.temp   = temp_r[14];

  btpc_div u_div (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .in_num(prod_d), .in_den(den_r[14]), .in_tag(div_tag_in),
    .out_quo(div_quo), .out_tag(div_tag_out)
  );

  // After the division: the P9 quadratic term and the P8 linear term.
  logic        pvld_r  [1:5];
  logic        ppv_r   [1:5];
  logic [15:0] ptemp_r [1:5];
  logic [63:0] pq_r    [1:4];
  logic [63:0] dq_r    [1:2];
  logic [63:0] pf_r    [3:4];
  logic [63:0] sum_r;
  logic [63:0] dq_c, prod_e, prod_f, prod_g, sum_c;
  logic [31:0] press_c;

  logic signed [15:0] temp_out_r;
  logic [31:0]        press_out_r;
  logic               pv_out_r;

  assign dq_c  = {{13{div_quo[63]}}, div_quo[63:13]};
  assign sum_c = pq_r[4] + {{25{prod_g[63]}}, prod_g[63:25]}
                 + {{19{pf_r[4][63]}}, pf_r[4][63:19]};
  assign press_c = sum_r[39:8] + {{12{p7[15]}}, p7, 4'b0000};

  btpc_mul64 u_mul_p9 (
    .clk(clk), .en(pipe_en),
    .a({{48{p9[15]}}, p9}), .b(dq_c), .p(prod_e)
  );

  btpc_mul64 u_mul_p8 (
    .clk(clk), .en(pipe_en),
    .a({{48{p8[15]}}, p8}), .b(div_quo), .p(prod_f)
  );

  btpc_mul64 u_mul_sq (
    .clk(clk), .en(pipe_en),
    .a(prod_e), .b(dq_r[2]), .p(prod_g)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 5; k++) pvld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      pvld_r[1] <= div_tag_out.vld;
      for (int k = 2; k <= 5; k++) pvld_r[k] <= pvld_r[k-1];
      out_vld_r <= pvld_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ppv_r[1]   <= div_tag_out.pvalid;
      ptemp_r[1] <= div_tag_out.temp;
      for (int k = 2; k <= 5; k++) begin
        ppv_r[k]   <= ppv_r[k-1];
        ptemp_r[k] <= ptemp_r[k-1];
      end
      pq_r[1] <= div_quo;
      for (int k = 2; k <= 4; k++) pq_r[k] <= pq_r[k-1];
      dq_r[1] <= dq_c;
      dq_r[2] <= dq_r[1];
      pf_r[3] <= prod_f;
      pf_r[4] <= pf_r[3];
      sum_r   <= sum_c;

      temp_out_r  <= ptemp_r[5];
      pv_out_r    <= ppv_r[5];
      press_out_r <= ppv_r[5] ? press_c : 32'd0;
    end
  end

  assign out_ch.valid                = out_vld_r;
  assign out_ch.temperature_centideg = temp_out_r;
  assign out_ch.pressure_q24_8       = press_out_r;
  assign out_ch.pressure_valid       = pv_out_r;

  // An accepted item always enters the first stage.
  `BTPC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[1], "accepted item did not enter the pipeline")
  // While stalled, two sampled valid bits inside the pipeline neither move nor vanish.
  `BTPC_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !pipe_en, $stable(vld_r[9]) && $stable(pvld_r[3]), "pipeline moved during a stall")
  // A result without a divisor reports zero pressure.
  `BTPC_ASSERT_NOW(a_no_div_zero, clk, rst_n, out_vld_r && !pv_out_r, press_out_r == 32'd0, "pressure not zero for a zero divisor")

endmodule

@@ tb/tb_baro_temp_pressure_compensation_core.sv @@
// Self-checking testbench for the barometric temperature and pressure compensation core.
// Depends on btpc_pkg, btpc_in_if, btpc_out_if and baro_temp_pressure_compensation_core.
`timescale 1ns / 1ps

module tb_baro_temp_pressure_compensation_core;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct {
    logic [15:0] temp;
    logic [31:0] press;
    logic        pvalid;
  } comp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  btpc_in_if in_ch ();
  btpc_out_if out_ch ();

  baro_temp_pressure_compensation_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // The testbench's own copy of the calibration registers, updated on every write.
  logic [47:0] temp_cal = '0;
  logic [63:0] press_cal_a = '0;
  logic [63:0] press_cal_b = '0;
  logic [15:0] press_cal_nine = '0;

  reading_t readings_pending[$];
  comp_t    results_due[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  function automatic logic signed [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed 64-bit division that truncates toward zero and wraps on overflow.
  function automatic logic signed [63:0] div_trunc(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Compensates one reading with the current calibration, in 64-bit wrapping arithmetic.
  function automatic comp_t compensate(reading_t r);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] adc_t, adc_p, v1, v2, d, fine, t, p;
    comp_t res;
    t1 = {48'd0, temp_cal[15:0]};
    t2 = sext16(temp_cal[31:16]);
    t3 = sext16(temp_cal[47:32]);
    p1 = {48'd0, press_cal_a[15:0]};
    p2 = sext16(press_cal_a[31:16]);
    p3 = sext16(press_cal_a[47:32]);
    p4 = sext16(press_cal_a[63:48]);
    p5 = sext16(press_cal_b[15:0]);
    p6 = sext16(press_cal_b[31:16]);
    p7 = sext16(press_cal_b[47:32]);
    p8 = sext16(press_cal_b[63:48]);
    p9 = sext16(press_cal_nine);
    adc_t = {44'd0, r.raw_t};
    adc_p = {44'd0, r.raw_p};

    // Fine temperature is kept at full width; only the final value saturates.
    v1 = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    t = (fine * 5 + 128) >>> 8;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    res.temp = t[15:0];

    v1 = fine - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    res.press = '0;
    res.pvalid = 1'b0;
    if (v1 != 0) begin
      p = 1048576 - adc_p;
      p = div_trunc(((p <<< 31) - v2) * 3125, v1);
      d = p >>> 13;
      v1 = (p9 * d * d) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      res.press = p[31:0];
      res.pvalid = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Driver: when an item is taken, its expected result is queued; then the next
  // item is offered unless the sender idles this cycle.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      results_due.push_back(compensate('{in_ch.raw_temperature, in_ch.raw_pressure}));
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (readings_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        reading_t r;
        r = readings_pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.raw_temperature <= r.raw_t;
        in_ch.raw_pressure <= r.raw_p;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares every taken result with the oldest expectation and
  // stalls the result channel at random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, temperature", out_ch.temperature_centideg, 0);
        end else begin
          comp_t want;
          want = results_due.pop_front();
          if (out_ch.temperature_centideg !== want.temp)
            report_mismatch("temperature", out_ch.temperature_centideg, want.temp);
          if (out_ch.pressure_q24_8 !== want.press)
            report_mismatch("pressure", out_ch.pressure_q24_8, want.press);
          if (out_ch.pressure_valid !== want.pvalid)
            report_mismatch("pressure_valid", out_ch.pressure_valid, want.pvalid);
        end
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(btpc_pkg::cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      btpc_pkg::CFG_TEMP_COEFFS: temp_cal = val[47:0];
      btpc_pkg::CFG_PRESS_A:     press_cal_a = val;
      btpc_pkg::CFG_PRESS_B:     press_cal_b = val;
      btpc_pkg::CFG_PRESS_NINE:  press_cal_nine = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                                  logic [15:0] p9);
    write_reg(btpc_pkg::CFG_TEMP_COEFFS, {16'd0, tc});
    write_reg(btpc_pkg::CFG_PRESS_A, pa);
    write_reg(btpc_pkg::CFG_PRESS_B, pb);
    write_reg(btpc_pkg::CFG_PRESS_NINE, {48'd0, p9});
  endtask

  // Waits until every offered item has been taken and every result has come back.
  // The queues and the handshake are looked at on the falling edge, when all
  // updates of the rising edge have settled.
  task automatic drain;
    do begin
      @(negedge clk);
    end while (readings_pending.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    reading_t r;
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        // Readings in the range a real sensor produces.
        r.raw_t = 20'($urandom_range(600000, 400000));
        r.raw_p = 20'($urandom_range(700000, 200000));
      end else begin
        r.raw_t = 20'($urandom);
        r.raw_p = 20'($urandom);
      end
      readings_pending.push_back(r);
    end
  endtask

  // Typical factory calibration of a part of this sensor family.
  localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TYP_P9 = 16'd6000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the field extremes; the reset calibration of all zeros
    // makes the pressure divisor zero.
    readings_pending.push_back('{20'd0, 20'd0});
    readings_pending.push_back('{20'hFFFFF, 20'hFFFFF});
    drain();
    load_calibration(TYP_T, TYP_PA, TYP_PB, TYP_P9);
    readings_pending.push_back('{20'd0, 20'd0});
    readings_pending.push_back('{20'hFFFFF, 20'hFFFFF});
    readings_pending.push_back('{20'hFFFFF, 20'd0});
    readings_pending.push_back('{20'd0, 20'hFFFFF});
    readings_pending.push_back('{20'h80000, 20'h7FFFF});
    readings_pending.push_back('{20'd519888, 20'd415148});
    readings_pending.push_back('{20'hAAAAA, 20'h55555});
    readings_pending.push_back('{20'h55555, 20'hAAAAA});
    drain();
    // Large coefficients make the pressure intermediates wrap.
    load_calibration({16'h8000, 16'h7FFF, 16'd0}, 64'h7FFF_7FFF_7FFF_FFFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    readings_pending.push_back('{20'hFFFFF, 20'd0});
    readings_pending.push_back('{20'd0, 20'hFFFFF});
    drain();
    load_calibration({16'h7FFF, 16'h8000, 16'hFFFF}, 64'h8000_8000_8000_FFFF,
                     64'h8000_8000_8000_8000, 16'h8000);
    readings_pending.push_back('{20'hFFFFF, 20'hFFFFF});
    readings_pending.push_back('{20'd0, 20'd0});
    drain();

    // Random phases over several calibrations; the idle pattern changes every
    // two phases, and each phase stops mid-way until the core is empty.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0:       begin send_idle_pct = 37; recv_idle_pct = 79; end
        1:       begin send_idle_pct = 79; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (ph)
        0: load_calibration(TYP_T, TYP_PA, TYP_PB, TYP_P9);
        1: load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom));
        2: load_calibration('1, '1, '1, '1);
        // Zero P1 leaves every pressure without a divisor.
        3: load_calibration(TYP_T, {TYP_PA[63:16], 16'd0}, TYP_PB, TYP_P9);
        4: load_calibration({TYP_T[47:16], 16'($urandom_range(30000, 25000))},
                            {TYP_PA[63:16], 16'($urandom_range(40000, 30000))},
                            {$urandom, $urandom}, 16'($urandom));
        default: load_calibration('0, '0, '0, '0);
      endcase
      queue_random(150);
      drain();
      queue_random(150);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
